@@ rtl/dcea_pkg.sv @@
// Shared constants, register codes and engine handshake types for the
// depth and color error accumulator. No dependencies.
package dcea_pkg;

  localparam int DEPTH_BITS       = 16;
  localparam int MAX_FRAME_PIXELS = 1048576;

  localparam int DW   = 16;  // depth field width
  localparam int CW   = 8;   // color channel width
  localparam int DAW  = 63;  // depth accumulator width
  localparam int CAW  = 48;  // color accumulator width
  localparam int NW   = 21;  // pixel counter width
  localparam int DERW = 32;  // per-pixel depth error width
  localparam int CDW  = 17;  // per-pixel color distance width (Q8)
  localparam int SQW  = 18;  // sum of squared channel differences
  localparam int UW   = 34;  // shared subtractor width

  localparam int CNT_FIELD_MAX = (1 << NW) - 1;
  localparam logic [NW-1:0] CNT_CAP =
    NW'((MAX_FRAME_PIXELS < CNT_FIELD_MAX) ? MAX_FRAME_PIXELS : CNT_FIELD_MAX);
  localparam logic [DW-1:0] DEPTH_MASK = DW'((1 << DEPTH_BITS) - 1);

  localparam logic REG_DEPTH_MODE  = 1'b0;
  localparam logic REG_RANGE_LIMIT = 1'b1;

  localparam logic MODE_ABS = 1'b0;
  localparam logic MODE_REL = 1'b1;

  typedef struct packed {
    logic           mode;
    logic [DW-1:0]  diff;
    logic [DW-1:0]  zref;
    logic [SQW-1:0] sq;
  } dcea_req_t;

  typedef struct packed {
    logic [DERW-1:0] derr;
    logic [CDW-1:0]  cdist;
  } dcea_res_t;

endpackage

@@ rtl/dcea_engine.sv @@
// Iterative error engine: relative depth division and rounded color
// square root on one shared compare-subtract unit. Depends on dcea_pkg.
module dcea_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  dcea_pkg::dcea_req_t req,
  output logic                done,
  output dcea_pkg::dcea_res_t res
);
  import dcea_pkg::*;

  localparam logic [1:0] E_IDLE = 2'd0;
  localparam logic [1:0] E_DIV  = 2'd1;
  localparam logic [1:0] E_SQRT = 2'd2;
  localparam logic [1:0] E_RND  = 2'd3;

  localparam int NQW = 2 * DW + 1;

  logic [1:0]     state;
  logic [5:0]     cnt;
  logic           mode;
  logic [DW-1:0]  diff;
  logic [NQW-1:0] nq;
  logic [DW:0]    dvs;
  logic [DW:0]    rem;
  logic [UW-1:0]  x;
  logic [UW-1:0]  r;
  logic [CDW-1:0] cdist;

  logic [UW-1:0]  ua;
  logic [UW-1:0]  ub;
  logic [UW-1:0]  udiff;
  logic           uge;
  logic [UW-1:0]  sbit;

  assign sbit = UW'(1) << {cnt[4:0], 1'b0};

  always_comb begin
    unique case (state)
      E_DIV: begin
        ua = UW'({rem, nq[NQW-1]});
        ub = UW'(dvs);
      end
      E_SQRT: begin
        ua = x;
        ub = r + sbit;
      end
      E_RND: begin
        ua = r;
        ub = x;
      end
      default: begin
        ua = '0;
        ub = '0;
      end
    endcase
    udiff = ua - ub;
    uge   = ua >= ub;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        E_IDLE: begin
          if (start) begin
            state <= (req.mode == MODE_REL) ? E_DIV : E_SQRT;
            cnt   <= (req.mode == MODE_REL) ? 6'(NQW - 1) : 6'(CDW - 1);
          end
        end
        E_DIV: begin
          if (cnt == '0) begin
            state <= E_SQRT;
            cnt   <= 6'(CDW - 1);
          end else begin
            cnt <= cnt - 6'd1;
          end
        end
        E_SQRT: begin
          if (cnt == '0) begin
            state <= E_RND;
          end else begin
            cnt <= cnt - 6'd1;
          end
        end
        E_RND: begin
          state <= E_IDLE;
          done  <= 1'b1;
        end
        default: state <= E_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      E_IDLE: begin
        if (start) begin
          mode <= req.mode;
          diff <= req.diff;
          nq   <= {req.diff, 1'b0, req.zref};
          dvs  <= {req.zref, 1'b0};
          rem  <= '0;
          x    <= {req.sq, 16'b0};
          r    <= '0;
        end
      end
      E_DIV: begin
        rem <= uge ? udiff[DW:0] : ua[DW:0];
        nq  <= {nq[NQW-2:0], uge};
      end
      E_SQRT: begin
        if (uge) begin
          x <= udiff;
          r <= (r >> 1) + sbit;
        end else begin
          r <= r >> 1;
        end
      end
      E_RND: cdist <= r[CDW-1:0] + CDW'(!uge);
      default: ;
    endcase
  end

  assign res.derr  = (mode == MODE_REL) ? nq[DERW-1:0] : DERW'(diff);
  assign res.cdist = cdist;

endmodule

@@ rtl/depth_color_error_accumulator.sv @@
// Top level: pixel intake, validity test, saturating frame sums and result
// register. Depends on dcea_pkg and dcea_engine.
//
// channel  dir  handshake          payload
// s        in   s_tvalid/s_tready  s_tdata (pixel pair), s_tlast (frame_end)
// m        out  m_tvalid/m_tready  m_tdata (three sums), m_tuser (saturated)
// cfg      in   cfg_we             cfg_index, cfg_data
//
// A matched pixel in relative mode passes accept, setup, 33 divide steps,
// 17 root steps, rounding and sum; absolute mode leaves out the divide steps.
// A skipped pixel passes accept and setup only. A frame-end item adds an
// emit step for the sums; dcea_engine runs the steps on one compare-subtract unit.
// Reset clears sums, count and flag and loads depth_mode 1, range limit 65535.
// A frame-end item waits while the previous result is still held on m.
module depth_color_error_accumulator (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // measured_depth, reference_depth, measured_red, measured_green,
  // measured_blue, reference_red, reference_green, reference_blue
  input  logic [79:0]  s_tdata,
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  // depth_error_sum, color_error_sum, matched_count, zero pad
  output logic [135:0] m_tdata,
  // saturated
  output logic         m_tuser,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [15:0]  cfg_data
);
  import dcea_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_WAIT = 3'd2;
  localparam logic [2:0] ST_EMIT = 3'd3;

  logic [2:0]    state;
  logic          depth_mode;
  logic [DW-1:0] range_limit;

  logic [DW-1:0] z;
  logic [DW-1:0] zref;
  logic [CW-1:0] mr, mg, mb, rr, rg, rb;
  logic          last;

  logic [DAW-1:0] dacc;
  logic [CAW-1:0] cacc;
  logic [NW-1:0]  cnt;
  logic           sat;

  logic [DAW-1:0] out_dsum;
  logic [CAW-1:0] out_csum;
  logic [NW-1:0]  out_cnt;
  logic           out_sat;

  logic           matched;
  logic [CW-1:0]  dr, dg, db;
  dcea_req_t      req;
  dcea_res_t      res;
  logic           eng_start;
  logic           eng_done;
  logic           out_free;
  logic           emit_now;
  logic [DAW:0]   dsum;
  logic [CAW:0]   csum;

  function automatic logic [CW-1:0] absd(input logic [CW-1:0] a, input logic [CW-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  always_comb begin
    matched   = (z != '0) && (zref != '0) && (z <= range_limit);
    dr        = absd(mr, rr);
    dg        = absd(mg, rg);
    db        = absd(mb, rb);
    req.mode  = depth_mode;
    req.diff  = (z > zref) ? z - zref : zref - z;
    req.zref  = zref;
    req.sq    = SQW'(dr) * SQW'(dr) + SQW'(dg) * SQW'(dg) + SQW'(db) * SQW'(db);
    eng_start = (state == ST_PREP) && matched;
    out_free  = !m_tvalid || m_tready;
    emit_now  = (state == ST_EMIT) && out_free;
    dsum      = {1'b0, dacc} + (DAW + 1)'(res.derr);
    csum      = {1'b0, cacc} + (CAW + 1)'(res.cdist);
  end

  dcea_engine u_engine (
    .clk   (clk),
    .rst   (rst),
    .start (eng_start),
    .req   (req),
    .done  (eng_done),
    .res   (res)
  );

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_mode  <= MODE_REL;
      range_limit <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEPTH_MODE:  depth_mode  <= cfg_data[0];
        REG_RANGE_LIMIT: range_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      z    <= s_tdata[15:0] & DEPTH_MASK;
      zref <= s_tdata[31:16] & DEPTH_MASK;
      mr   <= s_tdata[39:32];
      mg   <= s_tdata[47:40];
      mb   <= s_tdata[55:48];
      rr   <= s_tdata[63:56];
      rg   <= s_tdata[71:64];
      rb   <= s_tdata[79:72];
      last <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      dacc     <= '0;
      cacc     <= '0;
      cnt      <= '0;
      sat      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= emit_now || (m_tvalid && !m_tready);
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          priority if (matched) state <= ST_WAIT;
          else if (last)        state <= ST_EMIT;
          else                  state <= ST_IDLE;
        end
        ST_WAIT: begin
          if (eng_done) begin
            dacc <= dsum[DAW] ? '1 : dsum[DAW-1:0];
            cacc <= csum[CAW] ? '1 : csum[CAW-1:0];
            sat  <= sat || dsum[DAW] || csum[CAW] || (cnt == CNT_CAP);
            if (cnt != CNT_CAP) begin
              cnt <= cnt + NW'(1);
            end
            state <= last ? ST_EMIT : ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            dacc     <= '0;
            cacc     <= '0;
            cnt      <= '0;
            sat      <= 1'b0;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      out_dsum <= dacc;
      out_csum <= cacc;
      out_cnt  <= cnt;
      out_sat  <= sat;
    end
  end

  assign m_tdata = {4'b0, out_cnt, out_csum, out_dsum};
  assign m_tuser = out_sat;

`ifndef SYNTH
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    eng_done |-> state == ST_WAIT)
    else $error("engine result outside wait state");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_CAP)
    else $error("pixel count above cap");

  a_clear_on_emit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && out_free) |=> (cnt == '0 && !sat && m_tvalid))
    else $error("sums not cleared after result");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second item taken while busy");
`endif

endmodule

@@ test/depth_color_error_accumulator_tb.sv @@
// Self-checking testbench for depth_color_error_accumulator: directed and random
// pixel frames against a cycle-free predictor of the frame sums.
// Depends on dcea_pkg and the depth_color_error_accumulator RTL.
module depth_color_error_accumulator_tb;
  import dcea_pkg::*;

  localparam int ITEM_TARGET = 1850;
  localparam int SETTLE_CYCLES = 120;
  localparam int IDLE_LIMIT = 3000;
  localparam longint unsigned DEPTH_SUM_MAX = (64'd1 << DAW) - 1;
  localparam longint unsigned COLOR_SUM_MAX = (64'd1 << CAW) - 1;

  typedef struct {
    logic [DW-1:0] z;
    logic [DW-1:0] zref;
    logic [CW-1:0] mr, mg, mb;
    logic [CW-1:0] rr, rg, rb;
    bit            last;
  } pixel_t;

  typedef struct {
    logic [DAW-1:0] depth_sum;
    logic [CAW-1:0] color_sum;
    logic [NW-1:0]  count;
    logic           sat;
  } frame_sum_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [79:0]  s_tdata = '0;
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [135:0] m_tdata;
  logic         m_tuser;
  logic         cfg_we = 1'b0;
  logic         cfg_index = 1'b0;
  logic [15:0]  cfg_data = '0;

  depth_color_error_accumulator dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  logic            mode_q = MODE_REL;
  logic [DW-1:0]   range_q = 16'hFFFF;
  longint unsigned depth_total = 0;
  longint unsigned color_total = 0;
  longint unsigned match_count = 0;
  bit              sat_seen = 1'b0;
  frame_sum_t      frame_sums_q[$];
  frame_sum_t      want_sum;

  int errors = 0;
  int items_sent = 0;
  int burst_left = 0;
  bit steady_send = 1'b0;
  bit rx_steady = 1'b0;
  int rx_left = 0;
  int idle_cycles = 0;

  function automatic void clamp_add(inout longint unsigned acc, input longint unsigned add,
                                    input longint unsigned maxv);
    if (acc > maxv) acc = maxv;
    if (add > maxv - acc) begin
      acc = maxv;
      sat_seen = 1'b1;
    end else begin
      acc += add;
    end
  endfunction

  function automatic longint unsigned color_q8(input longint unsigned sq);
    longint unsigned v, r, t;
    v = sq << 16;
    r = 0;
    for (int b = 17; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    if (v - r * r > r) r++;
    return r;
  endfunction

  function automatic longint unsigned chan_sq(input logic [CW-1:0] a, input logic [CW-1:0] b);
    longint unsigned d;
    d = (a > b) ? a - b : b - a;
    return d * d;
  endfunction

  function automatic void accumulate_pixel(input pixel_t p);
    longint unsigned z, zr, diff, derr, sq;
    frame_sum_t r;
    z = p.z & DEPTH_MASK;
    zr = p.zref & DEPTH_MASK;
    if (z != 0 && zr != 0 && z <= range_q) begin
      diff = (z > zr) ? z - zr : zr - z;
      if (mode_q == MODE_ABS) derr = diff;
      else derr = (diff * 131072 + zr) / (2 * zr);
      sq = chan_sq(p.mr, p.rr) + chan_sq(p.mg, p.rg) + chan_sq(p.mb, p.rb);
      clamp_add(depth_total, derr, DEPTH_SUM_MAX);
      clamp_add(color_total, color_q8(sq), COLOR_SUM_MAX);
      clamp_add(match_count, 1, CNT_CAP);
    end
    if (p.last) begin
      r.depth_sum = depth_total[DAW-1:0];
      r.color_sum = color_total[CAW-1:0];
      r.count = match_count[NW-1:0];
      r.sat = sat_seen;
      frame_sums_q.insert(frame_sums_q.size(), r);
      depth_total = 0;
      color_total = 0;
      match_count = 0;
      sat_seen = 1'b0;
    end
  endfunction

  function automatic pixel_t pix(input int z, input int zr, input logic [23:0] mc,
                                 input logic [23:0] rc, input bit last);
    pixel_t p;
    p.z = z[15:0];
    p.zref = zr[15:0];
    {p.mb, p.mg, p.mr} = mc;
    {p.rb, p.rg, p.rr} = rc;
    p.last = last;
    return p;
  endfunction

  // Call at a falling edge; returns at a falling edge.
  task automatic send_pixel(input pixel_t p);
    int gap;
    s_tdata <= {p.rb, p.rg, p.rr, p.mb, p.mg, p.mr, p.zref, p.z};
    s_tlast <= p.last;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    accumulate_pixel(p);
    items_sent++;
    @(negedge clk);
    if (!steady_send) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(1, 15);
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_all_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (frame_sums_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    wait_all_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_DEPTH_MODE) mode_q = val[0];
    else range_q = val;
  endtask

  task automatic random_pixel(output pixel_t p, input bit last);
    int k, hi, d, t;
    {p.mr, p.mg, p.mb, p.rr, p.rg, p.rb} = 48'({$urandom, $urandom_range(0, 65535)});
    if ($urandom_range(0, 9) == 0) begin
      p.mr = {8{$urandom_range(0, 1) == 1}};
      p.mg = {8{$urandom_range(0, 1) == 1}};
      p.mb = {8{$urandom_range(0, 1) == 1}};
      p.rr = {8{$urandom_range(0, 1) == 1}};
      p.rg = {8{$urandom_range(0, 1) == 1}};
      p.rb = {8{$urandom_range(0, 1) == 1}};
    end
    hi = (range_q == 0) ? 65535 : int'(range_q);
    p.z = 16'($urandom_range(1, hi));
    if ($urandom_range(0, 1) == 1) begin
      p.zref = 16'($urandom_range(1, 65535));
    end else begin
      d = $urandom_range(0, 200);
      t = int'(p.z) + d - 100;
      if (t < 1) t = 1;
      if (t > 65535) t = 65535;
      p.zref = t[15:0];
    end
    k = $urandom_range(0, 99);
    if (k < 8) p.z = 0;
    else if (k < 14) p.zref = 0;
    else if (k < 17) begin
      p.z = 0;
      p.zref = 0;
    end else if (k < 23 && range_q < 16'hFFFF) p.z = 16'($urandom_range(range_q + 1, 65535));
    else if (k < 27) p.z = (range_q == 0) ? 16'd1 : range_q;
    p.last = last;
  endtask

  task automatic test_reset_config();
    send_pixel(pix(1000, 1200, 24'h102030, 24'h302010, 1'b0));
    send_pixel(pix(65535, 1, 24'h000000, 24'hFFFFFF, 1'b0));
    send_pixel(pix(1, 65535, 24'h7F7F7F, 24'h7F7F7F, 1'b1));
  endtask

  task automatic test_skip_rules();
    write_reg(REG_DEPTH_MODE, {15'd0, MODE_ABS});
    write_reg(REG_RANGE_LIMIT, 16'd1000);
    send_pixel(pix(0, 500, 24'h123456, 24'h654321, 1'b0));
    send_pixel(pix(500, 0, 24'h123456, 24'h654321, 1'b0));
    send_pixel(pix(0, 0, 24'hFFFFFF, 24'h000000, 1'b0));
    send_pixel(pix(1001, 1000, 24'hFFFFFF, 24'h000000, 1'b0));
    send_pixel(pix(1000, 1, 24'hFF00FF, 24'h00FF00, 1'b0));
    send_pixel(pix(0, 700, 24'h010203, 24'h040506, 1'b1));
    send_pixel(pix(2000, 2000, 24'h000000, 24'h000000, 1'b1));
  endtask

  task automatic test_zero_range();
    write_reg(REG_RANGE_LIMIT, 16'd0);
    send_pixel(pix(1, 1, 24'h00FF00, 24'hFF00FF, 1'b0));
    send_pixel(pix(65535, 65535, 24'h000000, 24'hFFFFFF, 1'b1));
    write_reg(REG_RANGE_LIMIT, 16'hFFFF);
  endtask

  task automatic test_abs_extremes();
    send_pixel(pix(65535, 1, 24'hFFFFFF, 24'h000000, 1'b0));
    send_pixel(pix(1, 65535, 24'h000000, 24'hFFFFFF, 1'b0));
    send_pixel(pix(4321, 4321, 24'hAA55AA, 24'h55AA55, 1'b1));
    send_pixel(pix(65535, 65535, 24'h000000, 24'h000000, 1'b1));
  endtask

  task automatic test_mode_switch();
    write_reg(REG_DEPTH_MODE, {15'd0, MODE_REL});
    send_pixel(pix(3000, 2000, 24'h0A0B0C, 24'h0C0B0A, 1'b0));
    write_reg(REG_DEPTH_MODE, {15'd0, MODE_ABS});
    send_pixel(pix(3000, 2000, 24'h0A0B0C, 24'h0C0B0A, 1'b1));
  endtask

  task automatic test_random_frames();
    int phase, len, flip_at;
    pixel_t p;
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase % 6)
        0: begin
          write_reg(REG_DEPTH_MODE, {15'd0, MODE_ABS});
          write_reg(REG_RANGE_LIMIT, 16'hFFFF);
        end
        1: begin
          write_reg(REG_DEPTH_MODE, {15'd0, MODE_REL});
          write_reg(REG_RANGE_LIMIT, 16'hFFFF);
        end
        2: write_reg(REG_RANGE_LIMIT, 16'd0);
        3: begin
          write_reg(REG_DEPTH_MODE, {15'd0, MODE_ABS});
          write_reg(REG_RANGE_LIMIT, 16'd1);
        end
        default: begin
          write_reg(REG_DEPTH_MODE, {15'd0, logic'($urandom_range(0, 1))});
          write_reg(REG_RANGE_LIMIT, 16'($urandom_range(2, 65534)));
        end
      endcase
      steady_send = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(4, 12)) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 16);
        flip_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len - 1) : -1;
        for (int i = 0; i < len; i++) begin
          if (i == flip_at) write_reg(REG_DEPTH_MODE, {15'd0, ~mode_q});
          random_pixel(p, i == len - 1);
          send_pixel(p);
        end
        if ($urandom_range(0, 15) == 0) wait_all_results();
      end
      phase++;
    end
  endtask

  always @(negedge clk) begin
    if (rx_left == 0) begin
      if (rx_steady || $urandom_range(0, 2) != 0) begin
        m_tready <= 1'b1;
        rx_left = $urandom_range(1, 10);
      end else begin
        m_tready <= 1'b0;
        rx_left = $urandom_range(1, 30);
      end
    end else begin
      rx_left--;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (frame_sums_q.size() == 0) begin
        $error("result item with none expected: m_tdata=%h m_tuser=%b", m_tdata, m_tuser);
        errors++;
      end else begin
        want_sum = frame_sums_q.pop_front();
        if (m_tdata[DAW-1:0] !== want_sum.depth_sum) begin
          $error("depth_error_sum expected %0d actual %0d", want_sum.depth_sum,
                 m_tdata[DAW-1:0]);
          errors++;
        end
        if (m_tdata[DAW+CAW-1:DAW] !== want_sum.color_sum) begin
          $error("color_error_sum expected %0d actual %0d", want_sum.color_sum,
                 m_tdata[DAW+CAW-1:DAW]);
          errors++;
        end
        if (m_tdata[DAW+CAW+NW-1:DAW+CAW] !== want_sum.count) begin
          $error("matched_count expected %0d actual %0d", want_sum.count,
                 m_tdata[DAW+CAW+NW-1:DAW+CAW]);
          errors++;
        end
        if (m_tuser !== want_sum.sat) begin
          $error("saturated expected %0b actual %0b", want_sum.sat, m_tuser);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("depth_color_error_accumulator_tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_config();
    test_skip_rules();
    test_zero_range();
    test_abs_extremes();
    test_mode_switch();
    test_random_frames();
    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("depth_color_error_accumulator_tb passed");
    end else begin
      $display("depth_color_error_accumulator_tb failed");
    end
    $finish;
  end

endmodule
